// File: src/rsct_pkg.sv
// Shared beat types, action and status codes, and a saturating-add helper for the ranked score table.
`default_nettype none

package rsct_pkg;

    // Action codes carried by a request beat
    localparam logic [2:0] ACT_ADD   = 3'd0;
    localparam logic [2:0] ACT_SUM   = 3'd1;
    localparam logic [2:0] ACT_PGPL  = 3'd2;
    localparam logic [2:0] ACT_PGNUM = 3'd3;
    localparam logic [2:0] ACT_CLEAN = 3'd4;

    // Status codes carried by a result beat
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [7:0]  MAX_ADD_RESET = 8'd60;
    localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] group;
        logic [9:0] player;
        logic [7:0] points;
        logic [9:0] page;
        logic [6:0] page_size;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] group_total;
        logic [9:0]  entry_player;
        logic [31:0] entry_points;
        logic [10:0] entry_rank;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [9:0]  player;
        logic [31:0] points;
    } tab_entry_t;

    // Add two 32-bit values, clamping at all ones
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

endpackage

`default_nettype wire

// File: src/rsct_div.sv
// Bit-serial remainder unit: position modulo page size, one dividend bit per cycle.
`default_nettype none

module rsct_div
    import rsct_pkg::*;
#(
    parameter int DW = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [6:0]    divisor,
    output logic               done,
    output logic [6:0]         rem
);

    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DW-1:0]   shift_reg, shift_next;
    logic [6:0]      rem_reg, rem_next;
    logic [6:0]      div_reg, div_next;
    logic [7:0]      trial;

    // Load the operands on start; else shift in one dividend bit and subtract the divisor when it fits
    always_comb
    begin
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        trial      = {rem_reg, shift_reg[DW-1]};
        if (start)
        begin
            cnt_next   = CNTW'(DW);
            busy_next  = 1'b1;
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = 7'(trial - {1'b0, div_reg});
            else
                rem_next = trial[6:0];
            shift_next = shift_reg << 1;
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// File: src/ranked_score_table_top.sv
// Ranked score table: per-group sorted tables and player position map kept in block memories.
// Request paths: sum, clean and bad arguments go from decode to the response; a page by number
//   goes to the page states; a player page reads the position map, then the remainder unit if
//   ranked; an add reads the map, fetches the entry if ranked, then moves past lower entries.
// Throughput: one request at a time; a page then gives one beat per cycle while it is taken.
// Reset: counts, totals and output valid clear at once; then all GROUPS*PLAYERS position map
//   entries are swept, one entry a cycle (also after every clean), before a request is taken.
`default_nettype none

module ranked_score_table_top
    import rsct_pkg::*;
#(
    parameter int GROUPS      = 16,
    parameter int PLAYERS     = 1024,
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_PAGE    = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire req_t       in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output rsp_t            out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    localparam int PW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int TDEPTH = GROUPS * TABLE_DEPTH;
    localparam int MDEPTH = GROUPS * PLAYERS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int MAW    = $clog2(MDEPTH);
    localparam int SW     = 18;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_MAPRD = 4'd3;
    localparam logic [3:0] S_OWN   = 4'd4;
    localparam logic [3:0] S_STEPI = 4'd5;
    localparam logic [3:0] S_STEP  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_PAGE  = 4'd9;
    localparam logic [3:0] S_PGOUT = 4'd10;
    localparam logic [3:0] S_RESP  = 4'd11;

    // Table and map storage
    tab_entry_t  tab_mem [0:TDEPTH-1];
    logic [PW:0] map_mem [0:MDEPTH-1];

    logic            tab_re, tab_we, map_re, map_we;
    logic [TAW-1:0]  tab_raddr, tab_waddr;
    logic [MAW-1:0]  map_raddr, map_waddr;
    tab_entry_t      tab_wdata, tab_rdata_reg;
    logic [PW:0]     map_wdata, map_rdata_reg;

    logic [3:0]      state_reg, state_next;
    req_t            req_reg, req_next;
    rsp_t            resp_reg, resp_next;
    rsp_t            out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    logic            clr_pend_reg, clr_pend_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [31:0]     score_reg, score_next;
    logic [SW-1:0]   start_reg, start_next;
    logic [6:0]      idx_reg, idx_next;
    logic [MAW-1:0]  clr_addr_reg, clr_addr_next;
    logic [7:0]      maxpts_reg;
    logic [CW-1:0]   count_reg [GROUPS];
    logic [CW-1:0]   count_next [GROUPS];
    logic [31:0]     total_reg [GROUPS];
    logic [31:0]     total_next [GROUPS];

    logic            div_start, div_done;
    logic [6:0]      div_rem;

    logic [GW-1:0]   g;
    logic            out_free, g_ok, pl_ok, pts_ok, size_ok, hit;
    logic [SW-1:0]   num_start, p_cur, p_nxt;
    logic [CW-1:0]   cnt_g;
    logic [31:0]     tot_g;

    function automatic logic [TAW-1:0] taddr(input logic [GW-1:0] gi, input logic [SW-1:0] p);
        return TAW'(32'(gi) * 32'(TABLE_DEPTH) + 32'(p));
    endfunction

    function automatic logic [MAW-1:0] maddr(input logic [GW-1:0] gi, input logic [9:0] pl);
        return MAW'(32'(gi) * 32'(PLAYERS) + 32'(pl));
    endfunction

    // Remainder unit for page-of-player start
    rsct_div #(.DW(PW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pos_next),
        .divisor  (req_reg.page_size),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Decode helpers for the held request
    always_comb
    begin
        g         = GW'(req_reg.group);
        g_ok      = 32'(req_reg.group) < 32'(GROUPS);
        pl_ok     = 32'(req_reg.player) < 32'(PLAYERS);
        pts_ok    = (req_reg.points != 8'd0) && (req_reg.points <= maxpts_reg);
        size_ok   = (req_reg.page_size != 7'd0) && (32'(req_reg.page_size) <= 32'(MAX_PAGE));
        cnt_g     = g_ok ? count_reg[g] : '0;
        tot_g     = g_ok ? total_reg[g] : '0;
        num_start = SW'(17'(req_reg.page - 10'd1) * 17'(req_reg.page_size));
        hit       = map_rdata_reg[PW] && (CW'(map_rdata_reg[PW-1:0]) < cnt_g);
        p_cur     = start_reg + SW'(idx_reg);
        p_nxt     = p_cur + SW'(1);
        out_free  = !out_valid_reg || out_ready;
    end

    // Request sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        resp_next      = resp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        clr_pend_next  = clr_pend_reg;
        pos_next       = pos_reg;
        score_next     = score_reg;
        start_next     = start_reg;
        idx_next       = idx_reg;
        clr_addr_next  = clr_addr_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        tab_re         = 1'b0;
        tab_raddr      = '0;
        tab_we         = 1'b0;
        tab_waddr      = '0;
        tab_wdata      = '0;
        map_re         = 1'b0;
        map_raddr      = '0;
        map_we         = 1'b0;
        map_waddr      = '0;
        map_wdata      = '0;
        div_start      = 1'b0;

        case (state_reg)
            S_CLR:
            begin
                // Sweep the position map to unranked
                map_we    = 1'b1;
                map_waddr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == MAW'(MDEPTH - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                resp_next        = '0;
                resp_next.status = ST_REJECT;
                resp_next.last   = 1'b1;
                clr_pend_next    = 1'b0;
                state_next       = S_RESP;
                case (req_reg.action)
                    ACT_ADD:
                    begin
                        if (g_ok && pl_ok && pts_ok)
                        begin
                            map_re     = 1'b1;
                            map_raddr  = maddr(g, req_reg.player);
                            state_next = S_MAPRD;
                        end
                    end
                    ACT_SUM:
                    begin
                        if (g_ok)
                        begin
                            resp_next.status      = ST_OK;
                            resp_next.group_total = tot_g;
                        end
                    end
                    ACT_PGPL:
                    begin
                        if (g_ok && pl_ok && size_ok)
                        begin
                            map_re     = 1'b1;
                            map_raddr  = maddr(g, req_reg.player);
                            state_next = S_MAPRD;
                        end
                    end
                    ACT_PGNUM:
                    begin
                        if (g_ok && size_ok && (req_reg.page != 10'd0)
                            && (num_start < SW'(cnt_g)))
                        begin
                            start_next = num_start;
                            idx_next   = '0;
                            state_next = S_PAGE;
                        end
                    end
                    ACT_CLEAN:
                    begin
                        for (int i = 0; i < GROUPS; i++)
                            count_next[i] = '0;
                        resp_next.status = ST_OK;
                        clr_pend_next    = 1'b1;
                    end
                    default:
                    begin
                        resp_next.status = ST_REJECT;
                    end
                endcase
            end
            S_MAPRD:
            begin
                if (req_reg.action == ACT_PGPL)
                begin
                    if (hit)
                    begin
                        pos_next   = map_rdata_reg[PW-1:0];
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (hit)
                begin
                    // Existing player: fetch its current entry
                    pos_next   = map_rdata_reg[PW-1:0];
                    tab_re     = 1'b1;
                    tab_raddr  = taddr(g, SW'(map_rdata_reg[PW-1:0]));
                    state_next = S_OWN;
                end
                else if (cnt_g >= CW'(TABLE_DEPTH))
                begin
                    resp_next.status = ST_FULL;
                    state_next       = S_RESP;
                end
                else
                begin
                    // New player: append at the end of the table
                    pos_next      = PW'(cnt_g);
                    count_next[g] = cnt_g + 1'b1;
                    score_next    = 32'(req_reg.points);
                    total_next[g] = sat_add(tot_g, 32'(req_reg.points));
                    state_next    = S_STEPI;
                end
            end
            S_OWN:
            begin
                score_next    = sat_add(tab_rdata_reg.points, 32'(req_reg.points));
                total_next[g] = sat_add(tot_g, 32'(req_reg.points));
                state_next    = S_STEPI;
            end
            S_STEPI:
            begin
                if (pos_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    tab_re     = 1'b1;
                    tab_raddr  = taddr(g, SW'(pos_reg) - SW'(1));
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                // Move the entry above down while it has fewer points
                if (tab_rdata_reg.points < score_reg)
                begin
                    tab_we    = 1'b1;
                    tab_waddr = taddr(g, SW'(pos_reg));
                    tab_wdata = tab_rdata_reg;
                    map_we    = 1'b1;
                    map_waddr = maddr(g, tab_rdata_reg.player);
                    map_wdata = {1'b1, pos_reg};
                    pos_next  = pos_reg - 1'b1;
                    if (pos_reg == PW'(1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        tab_re    = 1'b1;
                        tab_raddr = taddr(g, SW'(pos_reg) - SW'(2));
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                tab_we    = 1'b1;
                tab_waddr = taddr(g, SW'(pos_reg));
                tab_wdata.player = req_reg.player;
                tab_wdata.points = score_reg;
                map_we    = 1'b1;
                map_waddr = maddr(g, req_reg.player);
                map_wdata = {1'b1, pos_reg};
                resp_next.status       = ST_OK;
                resp_next.group_total  = tot_g;
                resp_next.entry_player = req_reg.player;
                resp_next.entry_points = score_reg;
                resp_next.entry_rank   = 11'(32'(pos_reg) + 32'd1);
                resp_next.last         = 1'b1;
                state_next             = S_RESP;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    start_next = SW'(pos_reg) - SW'(div_rem);
                    idx_next   = '0;
                    state_next = S_PAGE;
                end
            end
            S_PAGE:
            begin
                if (p_cur < SW'(cnt_g))
                begin
                    tab_re    = 1'b1;
                    tab_raddr = taddr(g, p_cur);
                end
                state_next = S_PGOUT;
            end
            S_PGOUT:
            begin
                // Emit one page beat, fetch the next position
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = '0;
                    out_next.status      = ST_OK;
                    out_next.group_total = tot_g;
                    if (p_cur < SW'(cnt_g))
                    begin
                        out_next.entry_player = tab_rdata_reg.player;
                        out_next.entry_points = tab_rdata_reg.points;
                        out_next.entry_rank   = 11'(p_nxt);
                    end
                    if (idx_reg == req_reg.page_size - 7'd1)
                    begin
                        out_next.last = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (p_nxt < SW'(cnt_g))
                        begin
                            tab_re    = 1'b1;
                            tab_raddr = taddr(g, p_nxt);
                        end
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = resp_reg;
                    state_next     = clr_pend_reg ? S_CLR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_MAPRD && req_reg.action == ACT_PGPL && hit)
            div_start = 1'b1;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
            clr_pend_reg  <= 1'b0;
            clr_addr_reg  <= '0;
            maxpts_reg    <= MAX_ADD_RESET;
            for (int i = 0; i < GROUPS; i++)
            begin
                count_reg[i] <= '0;
                total_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_pend_reg  <= clr_pend_next;
            clr_addr_reg  <= clr_addr_next;
            if (cfg_valid)
                maxpts_reg <= cfg_data;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        resp_reg  <= resp_next;
        out_reg   <= out_next;
        pos_reg   <= pos_next;
        score_reg <= score_next;
        start_reg <= start_next;
        idx_reg   <= idx_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[tab_waddr] <= tab_wdata;
        if (tab_re)
            tab_rdata_reg <= tab_mem[tab_raddr];
    end

    // Position map memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        if (map_re)
            map_rdata_reg <= map_mem[map_raddr];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: src/rsct_checker.sv
// Port-level checks for the ranked score table and their binding to the top level.
`default_nettype none

module rsct_checker
    import rsct_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire rsp_t out_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // One request at a time: no accept right after an accept
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    // A rejection or full status is a single closing beat
    a_rej_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |-> out_data.last)
        else $error("error status on a non-final beat");

    // An occupied position always carries a nonzero score
    a_rank_pts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.entry_rank != 11'd0) |-> (out_data.entry_points != 32'd0))
        else $error("ranked entry with zero points");

endmodule

bind ranked_score_table_top rsct_checker u_rsct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// File: bench/ranked_score_checker.sv
// Checker for the ranked score table: predicts every result beat and compares it on arrival.
`default_nettype none

module ranked_score_checker
    import rsct_pkg::*;
#(
    parameter int GROUPS      = 16,
    parameter int PLAYERS     = 1024,
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_PAGE    = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire req_t       in_data,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire rsp_t       out_data,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic [7:0] cfg_data,
    output int              fail_count,
    output int              pending,
    output int              beats_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the tables, the position map, counts, totals and the add limit
    logic [9:0]  slot_player [GROUPS][TABLE_DEPTH];
    logic [31:0] slot_points [GROUPS][TABLE_DEPTH];
    int unsigned where_is    [GROUPS][PLAYERS];
    bit          ranked      [GROUPS][PLAYERS];
    int unsigned fill        [GROUPS];
    logic [31:0] tally       [GROUPS];
    logic [7:0]  add_limit;

    rsp_t expected_beats[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        beats_seen = 0;
    end

    function automatic logic [31:0] clamp_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic push_beat(input logic [1:0] st, input logic [31:0] tot, input logic [9:0] pl,
                             input logic [31:0] pts, input logic [10:0] rank, input logic lst);
        rsp_t b;
        b.status       = st;
        b.group_total  = tot;
        b.entry_player = pl;
        b.entry_points = pts;
        b.entry_rank   = rank;
        b.last         = lst;
        expected_beats.push_back(b);
    endtask

    // Queue the beats of one page starting at table position first
    task automatic push_page(input int unsigned g, input int unsigned first, input int unsigned size);
        int unsigned p;
        for (int unsigned i = 0; i < size; i++)
        begin
            p = first + i;
            if (p < fill[g] && p < TABLE_DEPTH)
                push_beat(ST_OK, tally[g], slot_player[g][p], slot_points[g][p], 11'(p + 1),
                          i + 1 == size);
            else
                push_beat(ST_OK, tally[g], '0, '0, '0, i + 1 == size);
        end
    endtask

    task automatic wipe_tables();
        for (int g = 0; g < GROUPS; g++)
        begin
            fill[g] = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                slot_player[g][i] = '0;
                slot_points[g][i] = '0;
            end
            for (int i = 0; i < PLAYERS; i++)
            begin
                where_is[g][i] = 0;
                ranked[g][i]   = 0;
            end
        end
    endtask

    // Work out the result beats of one accepted request
    task automatic predict_request(input req_t r);
        int unsigned g, pl, pos, size;
        logic [31:0] score;
        logic [9:0]  moved;
        g    = r.group;
        pl   = r.player;
        size = r.page_size;
        case (r.action)
            ACT_ADD:
            begin
                if (g >= GROUPS || pl >= PLAYERS || r.points < 1 || r.points > add_limit)
                    push_beat(ST_REJECT, '0, '0, '0, '0, 1'b1);
                else if (!(ranked[g][pl] && where_is[g][pl] < fill[g])
                         && fill[g] >= TABLE_DEPTH)
                    push_beat(ST_FULL, '0, '0, '0, '0, 1'b1);
                else
                begin
                    if (ranked[g][pl] && where_is[g][pl] < fill[g])
                    begin
                        pos   = where_is[g][pl];
                        score = clamp_sum(slot_points[g][pos], {24'd0, r.points});
                    end
                    else
                    begin
                        pos     = fill[g];
                        fill[g] = pos + 1;
                        score   = {24'd0, r.points};
                    end
                    tally[g] = clamp_sum(tally[g], {24'd0, r.points});
                    // Move up past every entry with strictly fewer points
                    while (pos > 0 && slot_points[g][pos-1] < score)
                    begin
                        moved = slot_player[g][pos-1];
                        slot_player[g][pos] = moved;
                        slot_points[g][pos] = slot_points[g][pos-1];
                        where_is[g][moved] = pos;
                        ranked[g][moved]   = 1;
                        pos--;
                    end
                    slot_player[g][pos] = 10'(pl);
                    slot_points[g][pos] = score;
                    where_is[g][pl] = pos;
                    ranked[g][pl]   = 1;
                    push_beat(ST_OK, tally[g], 10'(pl), score, 11'(pos + 1), 1'b1);
                end
            end
            ACT_SUM:
                push_beat(ST_OK, tally[g], '0, '0, '0, 1'b1);
            ACT_PGPL:
            begin
                if (size < 1 || size > MAX_PAGE || !ranked[g][pl] || where_is[g][pl] >= fill[g])
                    push_beat(ST_REJECT, '0, '0, '0, '0, 1'b1);
                else
                    push_page(g, (where_is[g][pl] / size) * size, size);
            end
            ACT_PGNUM:
            begin
                if (size < 1 || size > MAX_PAGE || r.page < 1
                    || (r.page - 1) * size >= fill[g])
                    push_beat(ST_REJECT, '0, '0, '0, '0, 1'b1);
                else
                    push_page(g, (r.page - 1) * size, size);
            end
            ACT_CLEAN:
            begin
                wipe_tables();
                push_beat(ST_OK, '0, '0, '0, '0, 1'b1);
            end
            default:
                push_beat(ST_REJECT, '0, '0, '0, '0, 1'b1);
        endcase
    endtask

    // Compare arriving beats first, then predict the newly accepted request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_tables();
            for (int g = 0; g < GROUPS; g++)
                tally[g] = '0;
            add_limit = MAX_ADD_RESET;
            expected_beats.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                add_limit = cfg_data;
            if (out_valid && out_ready)
            begin
                beats_seen++;
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with no expectation: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    rsp_t e;
                    e = expected_beats.pop_front();
                    if (out_data.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.group_total !== e.group_total)
                    begin
                        $error("group_total exp %0d got %0d", e.group_total,
                               out_data.group_total);
                        fail_count++;
                    end
                    if (out_data.entry_player !== e.entry_player)
                    begin
                        $error("entry_player exp %0d got %0d", e.entry_player,
                               out_data.entry_player);
                        fail_count++;
                    end
                    if (out_data.entry_points !== e.entry_points)
                    begin
                        $error("entry_points exp %0d got %0d", e.entry_points,
                               out_data.entry_points);
                        fail_count++;
                    end
                    if (out_data.entry_rank !== e.entry_rank)
                    begin
                        $error("entry_rank exp %0d got %0d", e.entry_rank, out_data.entry_rank);
                        fail_count++;
                    end
                    if (out_data.last !== e.last)
                    begin
                        $error("last exp %0d got %0d", e.last, out_data.last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_request(in_data);
        end
        pending = expected_beats.size();
    end

endmodule

`default_nettype wire

// File: bench/tb_ranked_score_table_top.sv
// Testbench top for the ranked score table: clock, reset, request and config stimulus, verdict.
`default_nettype none

module tb_ranked_score_table_top;
    import rsct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 60000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    req_t       in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    rsp_t       out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    int  fail_count, pending, beats_seen;
    int  tx_idle = 12;
    int  rx_idle = 65;
    bit  long_hold_req = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    logic [7:0] cur_limit = MAX_ADD_RESET;

    ranked_score_table_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ranked_score_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .beats_seen (beats_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Drive the receiver ready, with a long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                stall_left    = 3000;
                long_hold_req = 0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Watchdog: count cycles in which no channel moves a beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("ranked_score_table_top test failed");
            $finish;
        end
    end

    // Offer one request beat and hold it until accepted, then maybe idle
    task automatic send_request(input req_t r);
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic make_req(output req_t r, input logic [2:0] act, input int g, input int pl,
                            input int pts, input int pg, input int size);
        r.action    = act;
        r.group     = 4'(g);
        r.player    = 10'(pl);
        r.points    = 8'(pts);
        r.page      = 10'(pg);
        r.page_size = 7'(size);
    endtask

    // Drain all results, then write the add limit while the block is idle
    task automatic write_limit(input logic [7:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_limit = v;
    endtask

    function automatic int pick_size();
        int k;
        k = $urandom_range(99);
        if (k < 80)
            return $urandom_range(1, 16);
        else if (k < 90)
            return $urandom_range(17, 64);
        return $urandom_range(127);
    endfunction

    // Build a mostly well-formed random request with random filler in unused fields
    function automatic req_t random_req();
        req_t r;
        int k;
        logic [2:0] pick;
        r = req_t'(44'({$urandom, $urandom}));
        k = $urandom_range(99);
        r.group = 4'(($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(3));
        if ($urandom_range(9) != 0)
            r.player = 10'($urandom_range(40));
        if (k < 45)
        begin
            r.action = ACT_ADD;
            r.points = 8'(($urandom_range(99) < 85) ? $urandom_range(1, cur_limit)
                                                    : $urandom_range(255));
        end
        else if (k < 55)
            r.action = ACT_SUM;
        else if (k < 72)
        begin
            r.action    = ACT_PGPL;
            r.page_size = 7'(pick_size());
        end
        else if (k < 92)
        begin
            r.action    = ACT_PGNUM;
            r.page_size = 7'(pick_size());
            if ($urandom_range(7) != 0)
                r.page = 10'($urandom_range(1, 6));
        end
        else if (k < 97)
            r.action = 3'($urandom_range(5, 7));
        else
        begin
            pick     = 3'($urandom_range(7));
            r.action = (pick == ACT_CLEAN) ? ACT_SUM : pick;
        end
        return r;
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            send_request(random_req());
    endtask

    initial
    begin
        req_t r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: limits, every action, ties, rejections, unknown actions, clean
        make_req(r, ACT_SUM, 0, 0, 0, 0, 0);          send_request(r);
        make_req(r, ACT_ADD, 0, 5, 1, 0, 0);          send_request(r);
        make_req(r, ACT_ADD, 0, 1023, 60, 1023, 127); send_request(r);
        make_req(r, ACT_ADD, 0, 7, 60, 0, 0);         send_request(r);
        make_req(r, ACT_ADD, 0, 8, 61, 0, 0);         send_request(r);
        make_req(r, ACT_ADD, 0, 9, 0, 0, 0);          send_request(r);
        make_req(r, ACT_ADD, 0, 5, 60, 0, 0);         send_request(r);
        make_req(r, ACT_ADD, 15, 0, 30, 0, 0);        send_request(r);
        make_req(r, ACT_PGPL, 0, 5, 0, 0, 1);         send_request(r);
        make_req(r, ACT_PGPL, 0, 7, 0, 0, 64);        send_request(r);
        make_req(r, ACT_PGPL, 0, 5, 0, 0, 0);         send_request(r);
        make_req(r, ACT_PGPL, 0, 5, 0, 0, 127);       send_request(r);
        make_req(r, ACT_PGPL, 0, 400, 0, 0, 4);       send_request(r);
        make_req(r, ACT_PGNUM, 0, 0, 0, 0, 4);        send_request(r);
        make_req(r, ACT_PGNUM, 0, 0, 0, 1, 64);       send_request(r);
        make_req(r, ACT_PGNUM, 0, 0, 0, 2, 2);        send_request(r);
        make_req(r, ACT_PGNUM, 0, 0, 0, 1023, 1);     send_request(r);
        make_req(r, 3'd5, 0, 0, 0, 0, 0);             send_request(r);
        make_req(r, 3'd6, 0, 0, 0, 0, 0);             send_request(r);
        make_req(r, 3'd7, 15, 1023, 255, 1023, 127);  send_request(r);
        make_req(r, ACT_SUM, 15, 0, 0, 0, 0);         send_request(r);
        make_req(r, ACT_CLEAN, 0, 0, 0, 0, 0);        send_request(r);
        make_req(r, ACT_SUM, 0, 0, 0, 0, 0);          send_request(r);
        make_req(r, ACT_PGNUM, 0, 0, 0, 1, 8);        send_request(r);

        // Sender idles little, receiver much; smallest limit with a long receiver hold-off, then limit 255
        write_limit(8'd1);
        long_hold_req = 1;
        run_random(60);
        write_limit(8'd255);
        run_random(60);

        // Pause the sender until every expected beat has come
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // Swap idling rates
        tx_idle = 65;
        rx_idle = 12;
        write_limit(8'($urandom_range(2, 254)));
        run_random(130);

        // No idling on either side, with one clean midway
        tx_idle = 0;
        rx_idle = 0;
        write_limit(8'd60);
        run_random(50);
        make_req(r, ACT_CLEAN, 0, 0, 0, 0, 0);
        send_request(r);
        run_random(60);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d requests (all actions, rejections, ties, clean) and %0d result beats",
                 items_sent, beats_seen);
        $display("under add limits 1, 255, random and 60, with idling, stalls and a long hold-off");
        if (fail_count == 0)
            $display("ranked_score_table_top test passed");
        else
            $display("ranked_score_table_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
